// File: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and defaults of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned OCC_W     = 7;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DELETE = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic                     func;
		logic signed [DATA_W-1:0] element_in;
		logic signed [DATA_W-1:0] priority_in;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] removed_element;
		logic signed [DATA_W-1:0] removed_priority;
		logic [OCC_W-1:0]         occupancy;
	} rsp_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] element;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_PLACE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic req_fire;
		logic req_delete;
		logic op_delete;
		logic full;
		logic empty;
		logic walk;
		logic pos_last;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic req_ready;
		logic rd_en;
		logic shift_wr;
		logic place_wr;
		logic take_front;
		logic load_out;
	} ctrl_t;

endpackage

// File: hw/rtl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/spq_fsm.sv
// ----------------------------------------------------------------------------
// spq_fsm
// Sequencer of the queue: accept, read/compare walk, place or take the front, respond.
// ----------------------------------------------------------------------------
module spq_fsm import spq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (stat.req_fire) begin
					if (stat.req_delete) begin
						state_d = stat.empty ? S_DONE : S_RD;
					end else if (stat.full) begin
						state_d = S_DONE;
					end else begin
						state_d = stat.empty ? S_PLACE : S_RD;
					end
				end
			end
			S_RD: state_d = S_CMP;
			S_CMP: begin
				priority if (stat.op_delete) begin
					state_d = S_DONE;
				end else if (stat.walk && !stat.pos_last) begin
					state_d = S_RD;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: state_d = S_DONE;
			S_DONE: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl            = '0;
		ctrl.req_ready  = (state_q == S_IDLE);
		ctrl.rd_en      = (state_q == S_RD);
		ctrl.shift_wr   = (state_q == S_CMP) && !stat.op_delete && stat.walk;
		ctrl.take_front = (state_q == S_CMP) && stat.op_delete;
		ctrl.place_wr   = (state_q == S_PLACE);
		ctrl.load_out   = (state_q == S_DONE) && stat.out_free;
	end

endmodule

// File: hw/rtl/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Sorted-array priority queue held in a ring buffer RAM, ordered by an
// insert walk that shares one read port and one priority comparator.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req (func, element_in, priority_in)
//   rsp      out  rsp_valid/rsp_ready    rsp (status, removed_*, occupancy)
//
// Delete: read the front, take it, respond. Overflow or underflow: respond without touching the RAM.
// Insert moving k entries walks from the back toward the front; each
// move is a RAM read followed by a compare-and-write through one port pair.
// req_ready is high only between transactions; a held response stalls the
// end of the next transaction, not its acceptance.
// Reset clears the count and ring head; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top import spq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	localparam int unsigned SUM_W  = CNT_W + 1;
	localparam int unsigned ENT_W  = $bits(entry_t);

	stat_t stat;
	ctrl_t ctrl;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  pos_q;
	logic [ADDR_W-1:0] head_q;
	logic              func_q;
	entry_t            item_q;
	logic [1:0]        status_q;
	entry_t            removed_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	entry_t            ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ENT_W-1:0]  ram_rdata;
	entry_t            rd_entry;
	logic [CNT_W-1:0]  rd_logical;
	logic [SUM_W-1:0]  head_next;

	function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
		input logic [CNT_W-1:0] lg);
		logic [SUM_W-1:0] s;
		s = SUM_W'(head) + SUM_W'(lg);
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return s[ADDR_W-1:0];
	endfunction

	spq_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign rd_entry   = entry_t'(ram_rdata);
	assign rd_logical = func_q ? '0 : pos_q - CNT_W'(1);
	assign ram_raddr  = phys(head_q, rd_logical);
	assign ram_we     = ctrl.shift_wr || ctrl.place_wr;
	assign ram_waddr  = phys(head_q, pos_q);
	assign ram_wdata  = ctrl.place_wr ? item_q : rd_entry;
	assign head_next  = SUM_W'(head_q) + SUM_W'(1);

	spq_ram #(
		.WIDTH (ENT_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ctrl.rd_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		stat            = '0;
		stat.req_fire   = req_valid && ctrl.req_ready;
		stat.req_delete = (req.func == FUNC_DELETE);
		stat.op_delete  = (func_q == FUNC_DELETE);
		stat.full       = (count_q == CNT_W'(DEPTH));
		stat.empty      = (count_q == '0);
		stat.walk       = (rd_entry.prio >= item_q.prio);
		stat.pos_last   = (pos_q == CNT_W'(1));
		stat.out_free   = !rsp_valid_q || rsp_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			head_q      <= '0;
			pos_q       <= '0;
			func_q      <= FUNC_INSERT;
			status_q    <= ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			if (stat.req_fire) begin
				func_q <= req.func;
				pos_q  <= count_q;
				if (stat.req_delete) begin
					status_q <= stat.empty ? ST_UNDERFLOW : ST_OK;
				end else begin
					status_q <= stat.full ? ST_OVERFLOW : ST_OK;
				end
			end
			if (ctrl.shift_wr) begin
				pos_q <= pos_q - CNT_W'(1);
			end
			if (ctrl.place_wr) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (ctrl.take_front) begin
				count_q <= count_q - CNT_W'(1);
				head_q  <= (head_next == SUM_W'(DEPTH)) ? '0 : head_next[ADDR_W-1:0];
			end
			if (ctrl.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.req_fire) begin
			item_q.element <= req.element_in;
			item_q.prio    <= req.priority_in;
			removed_q      <= '0;
		end
		if (ctrl.take_front) begin
			removed_q <= rd_entry;
		end
		if (ctrl.load_out) begin
			rsp_q.status           <= status_q;
			rsp_q.removed_element  <= removed_q.element;
			rsp_q.removed_priority <= removed_q.prio;
			rsp_q.occupancy        <= OCC_W'(count_q);
		end
	end

	assign req_ready = ctrl.req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.req_ready && !stat.op_delete |-> pos_q <= count_q)
		else $error("walk position beyond live entries");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ctrl.rd_en))
		else $error("RAM read and write in the same cycle");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out && status_q == ST_OVERFLOW |-> stat.full)
		else $error("overflow reported while not full");

	a_walk_live: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rd_en && !stat.op_delete |-> pos_q != '0)
		else $error("insert walk read below the front");

endmodule
